// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every rising clock edge outside reset
`define CHECK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be true outside reset
`define CHECK_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define CHECK_PROP(lbl, prop, msg)

`define CHECK_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/cidal_pkg.sv
// types and constants of the card id allow list
package cidal_pkg;

    localparam int UID_W       = 32;
    localparam int OP_W        = 3;
    localparam int TRIES_W     = 4;
    localparam int TIMER_W     = 24;
    localparam int STATUS_W    = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [UID_W-1:0]   DEFAULT_ID        = 32'hD11C0224;
    localparam logic [TRIES_W-1:0] MAX_TRIES_DEFAULT = 4'd5;
    localparam logic [TIMER_W-1:0] LOCKOUT_DEFAULT   = 24'd300000;
    localparam logic [TIMER_W-1:0] TIMER_MAX         = 24'hFFFFFF;

    localparam logic [OP_W-1:0] OP_CARD   = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
    localparam logic [OP_W-1:0] OP_NORMAL = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

    localparam logic [0:0] REG_MAX_TRIES = 1'b0;
    localparam logic [0:0] REG_LOCKOUT   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NONE       = 4'd0;
    localparam logic [STATUS_W-1:0] ST_MODE_SET   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_GRANTED    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_LOCK_START = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BLOCKED    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_ADDED      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_FULL       = 4'd7;
    localparam logic [STATUS_W-1:0] ST_EXISTS     = 4'd8;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd10;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 4'd11;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    // command broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic append_en;
        logic remove_en;
    } cell_cmd_t;

    // result item, last field (status) in the lowest bits
    typedef struct packed {
        logic [4:0]          pad;
        logic                lockout_expired;
        logic                tries_cleared;
        logic [TIMER_W-1:0]  remaining_ticks;
        logic [TRIES_W-1:0]  try_count;
        logic [4:0]          entry_count;
        logic [3:0]          match_index;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

// File: design/card_id_allow_list_with_lockout.sv
// card id allow list with wrong-try lockout, top level
// an input transfer is registered in idle, the cells compare and register their hits in the
// compare step, and the decide step loads the result into the output register; decide holds
//   while a result waits there and is not taken; one item is worked on at a time
// the next input is taken while a result waits in the output register
// reset (aresetn low, synchronous): list holds the default id, normal mode, timers clear
module card_id_allow_list_with_lockout
    import cidal_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // operation, card_uid, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status, match_index, entry_count,
                                              // try_count, remaining_ticks,
                                              // tries_cleared, lockout_expired, zero pad
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_addr,
    input  logic [TIMER_W-1:0]     cfg_wdata
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DECIDE
    } state_t;

    state_t             state_reg;
    logic [OP_W-1:0]    op_reg;
    logic [UID_W-1:0]   uid_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [TRIES_W-1:0] tries_reg;
    logic [TRIES_W-1:0] tries_next;
    logic [TIMER_W-1:0] elapsed_reg;
    logic [TIMER_W-1:0] elapsed_next;
    logic [TRIES_W-1:0] max_tries_reg;
    logic [TIMER_W-1:0] lock_ticks_reg;
    logic               m_tvalid_reg;
    out_item_t          out_reg;
    out_item_t          res;
    cell_cmd_t          cmd;
    logic               fire;

    logic [UID_W-1:0]      entries [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] hits;
    logic [IDX_W-1:0]      pos;
    logic                  found;

    logic               lock_check;
    logic               blocked;
    logic [TRIES_W-1:0] tries_eff;
    logic [TRIES_W:0]   tries_inc;

    // cell row
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [UID_W-1:0] nbr;
        if (i == LIST_DEPTH - 1) begin : g_last
            assign nbr = entries[i];
        end else begin : g_mid
            assign nbr = entries[i + 1];
        end
        cidal_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .IDX      (i),
            .HAS_INIT (i == 0)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .uid        (uid_reg),
            .pos        (pos),
            .count      (count_reg),
            .next_entry (nbr),
            .entry      (entries[i]),
            .hit        (hits[i])
        );
    end

    // first hit in the list
    always_comb begin
        pos   = '0;
        found = 1'b0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                pos   = IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    assign fire = (state_reg == S_DECIDE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        count_next   = count_reg;
        mode_next    = mode_reg;
        tries_next   = tries_reg;
        elapsed_next = elapsed_reg;
        res          = '0;
        cmd          = '0;
        cmd.cmp_en   = (state_reg == S_CMP);
        lock_check   = tries_reg >= max_tries_reg;
        blocked      = lock_check && (elapsed_reg < lock_ticks_reg);
        tries_eff    = (lock_check && !blocked) ? '0 : tries_reg;
        tries_inc    = {1'b0, tries_eff} + 1'b1;
        case (op_reg)
            OP_TICK: begin
                if (elapsed_reg != TIMER_MAX) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            OP_NORMAL, OP_ADD, OP_REMOVE: begin
                mode_next = (op_reg == OP_NORMAL) ? MODE_NORMAL :
                            (op_reg == OP_ADD) ? MODE_ADD : MODE_REMOVE;
                tries_next        = '0;
                res.tries_cleared = (tries_reg != '0);
                res.status        = ST_MODE_SET;
            end
            OP_CARD: begin
                if (blocked) begin
                    res.status          = ST_BLOCKED;
                    res.remaining_ticks = lock_ticks_reg - elapsed_reg;
                end else begin
                    res.lockout_expired = lock_check;
                    tries_next          = tries_eff;
                    case (mode_reg)
                        MODE_ADD: begin
                            if (found) begin
                                res.status      = ST_EXISTS;
                                res.match_index = 4'(pos);
                            end else if (count_reg == CNT_W'(LIST_DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                cmd.append_en = fire;
                                count_next    = count_reg + 1'b1;
                                res.status    = ST_ADDED;
                            end
                        end
                        MODE_REMOVE: begin
                            if (count_reg == '0) begin
                                res.status = ST_EMPTY;
                            end else if (found) begin
                                cmd.remove_en   = fire;
                                count_next      = count_reg - 1'b1;
                                res.status      = ST_REMOVED;
                                res.match_index = 4'(pos);
                            end else begin
                                res.status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (found) begin
                                res.status      = ST_GRANTED;
                                res.match_index = 4'(pos);
                                tries_next      = '0;
                            end else begin
                                res.status = ST_DENIED;
                                if (tries_eff < max_tries_reg) begin
                                    tries_next = tries_inc[TRIES_W-1:0];
                                    if (tries_inc[TRIES_W-1:0] == max_tries_reg) begin
                                        elapsed_next = '0;
                                        res.status   = ST_LOCK_START;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                res.status = ST_NONE;
            end
        endcase
        res.entry_count = 5'(count_next);
        res.try_count   = tries_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= CNT_W'(1);
            mode_reg       <= MODE_NORMAL;
            tries_reg      <= '0;
            elapsed_reg    <= '0;
            max_tries_reg  <= MAX_TRIES_DEFAULT;
            lock_ticks_reg <= LOCKOUT_DEFAULT;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MAX_TRIES: max_tries_reg  <= cfg_wdata[TRIES_W-1:0];
                    REG_LOCKOUT:   lock_ticks_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tdata[OP_W-1:0];
                        uid_reg   <= s_tdata[OP_W +: UID_W];
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (fire) begin
                        count_reg    <= count_next;
                        mode_reg     <= mode_next;
                        tries_reg    <= tries_next;
                        elapsed_reg  <= elapsed_next;
                        out_reg      <= res;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

`include "assert_macros.svh"

    `CHECK_NEVER(a_count_range, count_reg > CNT_W'(LIST_DEPTH), "entry count above list depth")
    `CHECK_PROP(a_fire_loads, fire |=> m_tvalid_reg && state_reg == S_IDLE, "result not loaded")
    `CHECK_PROP(a_grant_clears, m_tvalid_reg && out_reg.status == ST_GRANTED |-> out_reg.try_count == '0, "grant left tries")
    `CHECK_PROP(a_remaining_blocked, m_tvalid_reg && out_reg.remaining_ticks != '0 |-> out_reg.status == ST_BLOCKED, "remaining ticks outside block")

endmodule

// File: design/cidal_cell.sv
// one list cell: holds an id, compares it and shifts or appends
module cidal_cell
    import cidal_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0,
    parameter bit HAS_INIT = 1'b0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_cmd_t        cmd,
    input  logic [UID_W-1:0] uid,
    input  logic [IDX_W-1:0] pos,
    input  logic [CNT_W-1:0] count,
    input  logic [UID_W-1:0] next_entry,
    output logic [UID_W-1:0] entry,
    output logic             hit
);

    logic [UID_W-1:0] entry_reg;
    logic [UID_W-1:0] entry_next;
    logic             hit_reg;
    logic             in_list;
    logic             take_next;
    logic             take_uid;

    assign in_list   = CNT_W'(IDX) < count;
    assign take_next = cmd.remove_en && (IDX_W'(IDX) >= pos) && (CNT_W'(IDX + 1) < count);
    assign take_uid  = cmd.append_en && (count == CNT_W'(IDX));

    always_comb begin
        entry_next = entry_reg;
        if (take_next) begin
            entry_next = next_entry;
        end else if (take_uid) begin
            entry_next = uid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn && HAS_INIT) begin
            entry_reg <= DEFAULT_ID;
        end else begin
            entry_reg <= entry_next;
        end
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.cmp_en) begin
            hit_reg <= in_list && (entry_reg == uid);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// File: test/access_result_checker.sv
// result checker for the card id allow list: tracks list and lockout state, compares each result
`timescale 1ns / 1ps
module access_result_checker
    import cidal_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // operation, card_uid, zero pad
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,    // status, match_index, entry_count,
                                               // try_count, remaining_ticks,
                                               // tries_cleared, lockout_expired, zero pad
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_addr,
    input  logic [TIMER_W-1:0]     cfg_wdata,
    output int                     pending,
    output int                     mismatches,
    output int                     checked
);

    logic [UID_W-1:0]   id_list [LIST_DEPTH];
    int                 id_total;
    mode_t              access_mode;
    logic [TRIES_W-1:0] miss_run;
    logic [TIMER_W-1:0] ticks_since_lock;
    logic [TRIES_W-1:0] try_limit;
    logic [TIMER_W-1:0] lock_len;
    out_item_t          awaited_q [$];
    int                 bad_total = 0;
    int                 seen_total = 0;

    function automatic string show_item(input out_item_t t);
        return $sformatf("status %0d idx %0d count %0d tries %0d left %0d cleared %0b expired %0b",
                         t.status, t.match_index, t.entry_count, t.try_count,
                         t.remaining_ticks, t.tries_cleared, t.lockout_expired);
    endfunction

    function automatic out_item_t predict_access(input logic [OP_W-1:0] op,
                                                 input logic [UID_W-1:0] uid);
        out_item_t r;
        int        hit;
        logic      held;
        r    = '0;
        hit  = -1;
        held = 1'b0;
        case (op)
            OP_TICK: begin
                if (ticks_since_lock != TIMER_MAX) begin
                    ticks_since_lock++;
                end
            end
            OP_NORMAL, OP_ADD, OP_REMOVE: begin
                if (op == OP_NORMAL) begin
                    access_mode = MODE_NORMAL;
                end else if (op == OP_ADD) begin
                    access_mode = MODE_ADD;
                end else begin
                    access_mode = MODE_REMOVE;
                end
                if (miss_run != '0) begin
                    miss_run        = '0;
                    r.tries_cleared = 1'b1;
                end
                r.status = ST_MODE_SET;
            end
            OP_CARD: begin
                // lockout applies once the misses reach the limit
                if (miss_run >= try_limit) begin
                    if (ticks_since_lock < lock_len) begin
                        held              = 1'b1;
                        r.status          = ST_BLOCKED;
                        r.remaining_ticks = lock_len - ticks_since_lock;
                    end else begin
                        miss_run          = '0;
                        r.lockout_expired = 1'b1;
                    end
                end
                if (!held) begin
                    for (int i = 0; i < id_total; i++) begin
                        if (hit < 0 && id_list[i] == uid) begin
                            hit = i;
                        end
                    end
                    if (access_mode == MODE_ADD) begin
                        if (hit >= 0) begin
                            r.status      = ST_EXISTS;
                            r.match_index = hit[3:0];
                        end else if (id_total >= LIST_DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            id_list[id_total] = uid;
                            id_total++;
                            r.status = ST_ADDED;
                        end
                    end else if (access_mode == MODE_REMOVE) begin
                        if (id_total == 0) begin
                            r.status = ST_EMPTY;
                        end else if (hit >= 0) begin
                            // close the gap so the list stays compacted
                            for (int i = hit; i + 1 < id_total; i++) begin
                                id_list[i] = id_list[i + 1];
                            end
                            id_total--;
                            r.status      = ST_REMOVED;
                            r.match_index = hit[3:0];
                        end else begin
                            r.status = ST_NOT_FOUND;
                        end
                    end else if (hit >= 0) begin
                        r.status      = ST_GRANTED;
                        r.match_index = hit[3:0];
                        miss_run      = '0;
                    end else begin
                        r.status = ST_DENIED;
                        if (miss_run < try_limit) begin
                            miss_run++;
                            if (miss_run == try_limit) begin
                                ticks_since_lock = '0;
                                r.status         = ST_LOCK_START;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = 5'(id_total);
        r.try_count   = miss_run;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        if (!aresetn) begin
            foreach (id_list[i]) begin
                id_list[i] = '0;
            end
            id_list[0]       = DEFAULT_ID;
            id_total         = 1;
            access_mode      = MODE_NORMAL;
            miss_run         = '0;
            ticks_since_lock = '0;
            try_limit        = MAX_TRIES_DEFAULT;
            lock_len         = LOCKOUT_DEFAULT;
            awaited_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_MAX_TRIES) begin
                    try_limit = cfg_wdata[TRIES_W-1:0];
                end else begin
                    lock_len = cfg_wdata;
                end
            end
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata);
                seen_total++;
                if (awaited_q.size() == 0) begin
                    bad_total++;
                    if (bad_total <= 10) begin
                        $display("%0t: result with nothing awaited: %s", $realtime,
                                 show_item(got));
                    end
                end else begin
                    want = awaited_q.pop_front();
                    if (got.status !== want.status || got.match_index !== want.match_index ||
                        got.entry_count !== want.entry_count ||
                        got.try_count !== want.try_count ||
                        got.remaining_ticks !== want.remaining_ticks ||
                        got.tries_cleared !== want.tries_cleared ||
                        got.lockout_expired !== want.lockout_expired) begin
                        bad_total++;
                        if (bad_total <= 10) begin
                            $display("%0t: result %0d expected %s", $realtime, seen_total,
                                     show_item(want));
                            $display("%0t: result %0d actual   %s", $realtime, seen_total,
                                     show_item(got));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_q.push_back(predict_access(s_tdata[OP_W-1:0], s_tdata[OP_W +: UID_W]));
            end
        end
        pending    <= awaited_q.size();
        mismatches <= bad_total;
        checked    <= seen_total;
    end

endmodule

// File: test/tb_card_id_allow_list_with_lockout.sv
// testbench top for the card id allow list: drives transfers and register writes, gives the verdict
`timescale 1ns / 1ps
module tb_card_id_allow_list_with_lockout;
    import cidal_pkg::*;

    localparam int  LIST_DEPTH   = 16;
    localparam int  POOL_SIZE    = 24;
    localparam int  DUT_LATENCY  = 3;
    localparam int  PHASE_ITEMS  = 70;
    localparam int  PHASES       = 7;
    localparam real RUN_LIMIT_NS = 5.0e6;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY
    } stall_style_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [0:0]             cfg_addr  = REG_MAX_TRIES;
    logic [TIMER_W-1:0]     cfg_wdata = '0;
    int                     pending;
    int                     mismatches;
    int                     checked;

    logic [UID_W-1:0]   id_pool [POOL_SIZE];
    int                 burst_left;
    int                 items_sent    = 0;
    int                 settings_used = 0;
    stall_style_t       stall_style   = STALL_NONE;
    int                 stall_hold    = 0;
    logic [TRIES_W-1:0] limit_plan [PHASES] = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd2, 4'd4, 4'd5};
    logic [TIMER_W-1:0] ticks_plan [PHASES] = '{24'd1, 24'hFFFFFF, 24'd8, 24'd4, 24'd30,
                                                24'd2, 24'd300000};

    card_id_allow_list_with_lockout #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    access_result_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .mismatches (mismatches),
        .checked    (checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver backpressure: none, coin-flip or heavy, picked anew when its hold count runs out
    always @(posedge aclk) begin
        if (stall_hold == 0) begin
            stall_style = stall_style_t'($urandom_range(0, 2));
            stall_hold  = $urandom_range(32, 200);
        end
        stall_hold--;
        case (stall_style)
            STALL_NONE: begin
                m_tready <= 1'b1;
            end
            STALL_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid);
        s_tdata  <= {{(IN_TDATA_W - OP_W - UID_W){1'b0}}, uid, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DUT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [TRIES_W-1:0] tries, input logic [TIMER_W-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MAX_TRIES;
        cfg_wdata <= TIMER_W'(tries);
        @(posedge aclk);
        cfg_addr  <= REG_LOCKOUT;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // mostly known ids so grants, duplicates and removals happen, plus ticks, mode changes and unknown op codes
    task automatic send_random_item();
        int               pick;
        logic [UID_W-1:0] uid;
        pick = $urandom_range(0, 99);
        uid  = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 50) begin
            send_item(OP_CARD, uid);
        end else if (pick < 60) begin
            send_item(OP_CARD, $urandom());
        end else if (pick < 78) begin
            send_item(OP_TICK, $urandom());
        end else if (pick < 86) begin
            send_item(OP_NORMAL, $urandom());
        end else if (pick < 91) begin
            send_item(OP_ADD, $urandom());
        end else if (pick < 94) begin
            send_item(OP_REMOVE, $urandom());
        end else if (pick < 97) begin
            send_item(OP_REMOVE + OP_W'($urandom_range(1, 3)), $urandom());
        end else begin
            send_item(OP_CARD, ($urandom_range(0, 1) != 0) ? '1 : '0);
        end
    endtask

    initial begin
        id_pool[0] = DEFAULT_ID;
        for (int i = 1; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom();
        end
        burst_left = $urandom_range(1, 40);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset limits: grant, misses, unknown codes, list edits down to empty
        send_item(OP_CARD, DEFAULT_ID);
        send_item(OP_CARD, 32'h0000_0000);
        send_item(OP_CARD, 32'hFFFF_FFFF);
        send_item(OP_REMOVE + OP_W'(1), 32'h5555_5555);
        send_item(OP_REMOVE + OP_W'(3), 32'hAAAA_AAAA);
        send_item(OP_NORMAL, 32'h0);
        send_item(OP_ADD, 32'h0);
        send_item(OP_CARD, 32'hFFFF_FFFF);
        send_item(OP_CARD, DEFAULT_ID);
        send_item(OP_REMOVE, 32'h0);
        send_item(OP_CARD, DEFAULT_ID);
        send_item(OP_CARD, 32'h1234_5678);
        send_item(OP_CARD, 32'hFFFF_FFFF);
        send_item(OP_CARD, 32'h8765_4321);
        send_item(OP_NORMAL, 32'h0);
        send_item(OP_TICK, 32'h0);
        wait_idle();

        // short lockout: start, blocked countdown, expiry on the next card
        set_limits(4'd2, 24'd3);
        send_item(OP_CARD, 32'hA5A5_A5A5);
        send_item(OP_CARD, 32'h5A5A_5A5A);
        send_item(OP_CARD, 32'hA5A5_A5A5);
        send_item(OP_TICK, 32'h0);
        send_item(OP_CARD, 32'hA5A5_A5A5);
        send_item(OP_TICK, 32'h0);
        send_item(OP_TICK, 32'h0);
        send_item(OP_CARD, 32'h0BAD_CAFE);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            set_limits(limit_plan[p], ticks_plan[p]);
            repeat (PHASE_ITEMS) send_random_item();
            wait_idle();
        end
        repeat (4 * DUT_LATENCY) @(posedge aclk);

        $display("covered %0d transfers in, %0d results compared, %0d limit settings after reset",
                 items_sent, checked, settings_used);
        $display("mismatches %0d, results still awaited %0d", mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
